// ----- hdl/interarrival_jitter_stats_core_assert.svh -----
// Assertion macros for the interarrival jitter statistics core.
// No dependencies; included by the top level only.
`ifndef INTERARRIVAL_JITTER_STATS_CORE_ASSERT_SVH
`define INTERARRIVAL_JITTER_STATS_CORE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define IJS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define IJS_ASSERT_NEXT(name, clk, rst_n, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/ijs_pkg.sv -----
// Shared types and constants of the interarrival jitter statistics core.
// No dependencies.
package ijs_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned SecW   = 32;
  localparam int unsigned UsecW  = 20;
  localparam int unsigned HalfW  = TimeW / 2;

  localparam logic [SecW-1:0]  USEC_PER_SEC = SecW'(1000000);
  localparam logic [TimeW-1:0] MIN_RESET    = '1;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_EXPORT  = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [SecW-1:0]  time_seconds;
    logic [UsecW-1:0] time_microseconds;
  } ijs_in_t;

  typedef struct packed {
    logic [CountW-1:0] interval_count;
    logic [TimeW-1:0]  min_gap;
    logic [TimeW-1:0]  avg_gap;
    logic [TimeW-1:0]  max_gap;
    logic [TimeW-1:0]  gap_variance;
  } ijs_out_t;

  typedef struct packed {
    logic              start;
    logic [TimeW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/ijs_mul.sv -----
// Shared 32 x 32 multiplier with a registered 64-bit product.
// Depends on ijs_pkg.
module ijs_mul
  import ijs_pkg::*;
(
  input  logic             clk_i,
  input  logic [HalfW-1:0] a_i,
  input  logic [HalfW-1:0] b_i,
  output logic [TimeW-1:0] prod_o
);

  logic [TimeW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= TimeW'(a_i) * TimeW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ----- hdl/ijs_div.sv -----
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on ijs_pkg.
module ijs_div
  import ijs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(TimeW);

  logic [CountW-1:0] rem_q;
  logic [TimeW-1:0]  quo_q;
  logic [CountW-1:0] den_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [CountW:0] trial;
  logic [CountW:0] diff;
  logic            ge;

  assign trial = {rem_q, quo_q[TimeW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(TimeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_q <= ge ? diff[CountW-1:0] : trial[CountW-1:0];
      quo_q <= {quo_q[TimeW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ----- hdl/interarrival_jitter_stats_core.sv -----
// Arrival: the first one only sets the start time; later ones add a gap and its square; a result is never made.
// Export with fewer than two intervals: straight to the output state, which loads the output register once it is free.
// Export otherwise: three 64-step divisions in turn on the shared divider, then the output state.
// One request at a time; an arrival may run while a result waits to be taken.
// Reset (rst_ni low, asynchronous): no start time, empty statistics, no result pending.
module interarrival_jitter_stats_core
  import ijs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ijs_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ijs_out_t out_rsp_o
);

`include "interarrival_jitter_stats_core_assert.svh"

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_A_TIME   = 4'd1;
  localparam logic [3:0] S_A_GAP    = 4'd2;
  localparam logic [3:0] S_A_UPD    = 4'd3;
  localparam logic [3:0] S_A_SQ0    = 4'd4;
  localparam logic [3:0] S_A_SQ1    = 4'd5;
  localparam logic [3:0] S_A_SQ2    = 4'd6;
  localparam logic [3:0] S_E_AVG    = 4'd7;
  localparam logic [3:0] S_E_SQ0    = 4'd8;
  localparam logic [3:0] S_E_SQ1    = 4'd9;
  localparam logic [3:0] S_E_SQ2    = 4'd10;
  localparam logic [3:0] S_E_AVG_W  = 4'd11;
  localparam logic [3:0] S_E_MEAN   = 4'd12;
  localparam logic [3:0] S_E_MEAN_W = 4'd13;
  localparam logic [3:0] S_E_VAR_W  = 4'd14;
  localparam logic [3:0] S_E_OUT    = 4'd15;

  logic [3:0] state_q;

  logic [SecW-1:0]   secs_q;
  logic [UsecW-1:0]  usecs_q;
  logic              started_q;
  logic [TimeW-1:0]  start_q;
  logic [TimeW-1:0]  last_q;
  logic [TimeW-1:0]  min_q;
  logic [TimeW-1:0]  max_q;
  logic [TimeW-1:0]  sum_q;
  logic [TimeW-1:0]  sq_q;
  logic [CountW-1:0] cnt_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  x_q;
  logic [TimeW-1:0]  tmp_q;
  logic [TimeW-1:0]  avg_q;
  logic [TimeW-1:0]  var_q;
  logic              out_valid_q;
  ijs_out_t          out_q;

  logic [HalfW-1:0] mul_a;
  logic [HalfW-1:0] mul_b;
  logic [TimeW-1:0] prod;
  logic [TimeW-1:0] cross_term;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] gap;
  logic             multi;
  logic             out_free;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign now        = prod + TimeW'(usecs_q);
  assign gap        = now_q - last_q;
  assign cross_term = {prod[HalfW-2:0], {(HalfW+1){1'b0}}};
  assign multi      = |cnt_q[CountW-1:1];
  assign out_free   = !out_valid_q || out_ready_i;

  ijs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ijs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // square low*low first, then the low*high cross term
  always_comb begin
    mul_a = x_q[HalfW-1:0];
    mul_b = x_q[HalfW-1:0];
    case (state_q)
      S_A_TIME: begin
        mul_a = secs_q;
        mul_b = USEC_PER_SEC;
      end
      S_A_SQ1, S_E_SQ1: begin
        mul_b = x_q[TimeW-1:HalfW];
      end
      default: begin
        mul_a = x_q[HalfW-1:0];
        mul_b = x_q[HalfW-1:0];
      end
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = last_q - start_q;
    div_req.divisor  = cnt_q;
    case (state_q)
      S_E_AVG: begin
        div_req.start = 1'b1;
      end
      S_E_MEAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = tmp_q;
      end
      S_E_MEAN_W: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = sq_q - div_rsp.quotient;
        div_req.divisor  = cnt_q - 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      start_q     <= '0;
      last_q      <= '0;
      min_q       <= MIN_RESET;
      max_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_E_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_req_i.opcode == OP_ARRIVAL) begin
              state_q <= S_A_TIME;
            end else if (multi) begin
              state_q <= S_E_AVG;
            end else begin
              state_q <= S_E_OUT;
            end
          end
        end
        S_A_TIME: begin
          state_q <= S_A_GAP;
        end
        S_A_GAP: begin
          if (started_q) begin
            state_q <= S_A_UPD;
          end else begin
            started_q <= 1'b1;
            start_q   <= now;
            last_q    <= now;
            state_q   <= S_IDLE;
          end
        end
        S_A_UPD: begin
          if (gap < min_q) begin
            min_q <= gap;
          end
          if (gap > max_q) begin
            max_q <= gap;
          end
          sum_q   <= sum_q + gap;
          cnt_q   <= cnt_q + 1'b1;
          last_q  <= now_q;
          state_q <= S_A_SQ0;
        end
        S_A_SQ0: begin
          state_q <= S_A_SQ1;
        end
        S_A_SQ1: begin
          sq_q    <= sq_q + prod;
          state_q <= S_A_SQ2;
        end
        S_A_SQ2: begin
          sq_q    <= sq_q + cross_term;
          state_q <= S_IDLE;
        end
        S_E_AVG: begin
          state_q <= S_E_SQ0;
        end
        S_E_SQ0: begin
          state_q <= S_E_SQ1;
        end
        S_E_SQ1: begin
          state_q <= S_E_SQ2;
        end
        S_E_SQ2: begin
          state_q <= S_E_AVG_W;
        end
        S_E_AVG_W: begin
          if (div_rsp.done) begin
            state_q <= S_E_MEAN;
          end
        end
        S_E_MEAN: begin
          state_q <= S_E_MEAN_W;
        end
        S_E_MEAN_W: begin
          if (div_rsp.done) begin
            state_q <= S_E_VAR_W;
          end
        end
        S_E_VAR_W: begin
          if (div_rsp.done) begin
            state_q <= S_E_OUT;
          end
        end
        S_E_OUT: begin
          // hold until the output register is free, then restart the interval
          if (out_free) begin
            start_q     <= last_q;
            min_q       <= MIN_RESET;
            max_q       <= '0;
            sum_q       <= '0;
            sq_q        <= '0;
            cnt_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      secs_q  <= in_req_i.time_seconds;
      usecs_q <= in_req_i.time_microseconds;
    end
    if (state_q == S_A_GAP) begin
      now_q <= now;
    end
    if (state_q == S_A_UPD) begin
      x_q <= gap;
    end
    if (state_q == S_E_AVG) begin
      x_q <= sum_q;
    end
    if (state_q == S_E_SQ1) begin
      tmp_q <= prod;
    end
    if (state_q == S_E_SQ2) begin
      tmp_q <= tmp_q + cross_term;
    end
    if (state_q == S_E_AVG_W && div_rsp.done) begin
      avg_q <= div_rsp.quotient;
    end
    if (state_q == S_E_VAR_W && div_rsp.done) begin
      var_q <= div_rsp.quotient;
    end
    if (state_q == S_E_OUT && out_free) begin
      out_q.interval_count <= cnt_q;
      out_q.min_gap        <= multi ? min_q : '0;
      out_q.avg_gap        <= multi ? avg_q : '0;
      out_q.max_gap        <= multi ? max_q : '0;
      out_q.gap_variance   <= multi ? var_q : '0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `IJS_ASSERT(a_div_done_expected, clk_i, rst_ni,
    !div_rsp.done || state_q == S_E_AVG_W || state_q == S_E_MEAN_W || state_q == S_E_VAR_W,
    "divider finished outside a wait state")
  `IJS_ASSERT(a_min_le_max, clk_i, rst_ni, cnt_q == '0 || min_q <= max_q,
    "running minimum above running maximum")
  `IJS_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, state_q == S_E_OUT && out_free,
    out_valid_o && state_q == S_IDLE && cnt_q == '0, "export did not load a result")

endmodule
